// ===== rtl/sgr_pkg.sv =====
// Shared types and constants for the slash grid reachability block.
package sgr_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_DEGREE = 2'd1,
    ACT_PATH   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_FWD   = 2'd1;
  localparam logic [1:0] CELL_BACK  = 2'd2;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  // Four diagonal links around a node, in the order they are probed.
  typedef enum logic [1:0] {
    DIR_UL = 2'd0,
    DIR_UR = 2'd1,
    DIR_DL = 2'd2,
    DIR_DR = 2'd3
  } dir_t;

endpackage

// ===== rtl/slash_grid_reachability_top.sv =====
// Top level of the slash grid reachability block: cell memory, search engine and handshakes.
//
// A valid cell write is stored at its transfer and the block can take the next item in the
// next cycle. A degree query probes the four cells around the node one at a time, each
// with a read state and a check state, and then offers its result. An item with a bad
// coordinate offers its result in the cycle after the transfer. A path query first clears
// the visited map, one entry per cycle over all (MAX_ROWS+1)*(MAX_COLS+1) entries, then
// takes each dequeued node through a pop state and a read state and probes its four neighbor
// cells one at a time through the single read port of the cell memory; for each linked
// neighbor the visited bit is then read through the visited memory and, if still clear,
// set while the neighbor is queued. Items are handled one at a time. After reset all
// MAX_ROWS*MAX_COLS cells of the cell memory are cleared before the first item is taken.
module slash_grid_reachability_top
  import sgr_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [4:0] node_row,
  input  logic [4:0] node_col,
  input  logic [4:0] target_row,
  input  logic [4:0] target_col,
  input  logic [1:0] cell_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] degree,
  output logic       reachable,
  output logic       bad_coordinate,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int NCOLS = MAX_COLS + 1;
  localparam int NODES = (MAX_ROWS + 1) * (MAX_COLS + 1);
  localparam int CW = $clog2(CELLS);
  localparam int NW = $clog2(NODES);
  localparam int QW = $clog2(NODES + 1);
  localparam logic [4:0] MAXR = 5'(MAX_ROWS);
  localparam logic [4:0] MAXC = 5'(MAX_COLS);

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DEG   = 13'b0000000000100,
    S_DEGRD = 13'b0000000001000,
    S_VCLR  = 13'b0000000010000,
    S_POP   = 13'b0000000100000,
    S_POPRD = 13'b0000001000000,
    S_NBR   = 13'b0000010000000,
    S_NBRRD = 13'b0000100000000,
    S_VRD   = 13'b0001000000000,
    S_VCHK  = 13'b0010000000000,
    S_OUT   = 13'b0100000000000,
    S_START = 13'b1000000000000
  } state_t;

  state_t state;
  logic [4:0] grid_rows, grid_cols;
  logic [4:0] cr, cc, tr, tc;     // current node and target
  logic [4:0] nr, nc;             // neighbor node
  logic [1:0] dir;
  logic [2:0] deg_cnt;
  logic [QW-1:0] head, tail, sweep;
  logic res_deg;
  logic [2:0] res_degree;
  logic res_reach, res_bad;

  logic [1:0] cell_mem [CELLS];
  logic [0:0] vis_mem [NODES];
  logic [9:0] queue_mem [NODES];
  logic [1:0] cell_q;
  logic [0:0] vis_q;
  logic [9:0] queue_q;

  logic cell_we, vis_we, q_we;
  logic [CW-1:0] cell_wa, cell_ra;
  logic [1:0] cell_wd;
  logic [NW-1:0] vis_wa, vis_ra, q_wa, q_ra;
  logic vis_wd;
  logic [9:0] q_wd;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_q <= cell_mem[cell_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
    if (q_we) queue_mem[q_wa] <= q_wd;
    queue_q <= queue_mem[q_ra];
  end

  function automatic logic [4:0] clamp(input logic [4:0] v, input logic [4:0] m);
    if (v == 5'd0) return 5'd1;
    if (v > m) return m;
    return v;
  endfunction

  // Probe geometry for the current direction.
  logic probe_ok;
  logic [4:0] pr, pc;   // cell to probe
  logic [1:0] want;
  always_comb begin
    probe_ok = 1'b0;
    pr = cr;
    pc = cc;
    want = CELL_BACK;
    nr = cr;
    nc = cc;
    unique case (dir_t'(dir))
      DIR_UL: begin
        probe_ok = (cr != 5'd0) && (cc != 5'd0);
        pr = cr - 5'd1; pc = cc - 5'd1; want = CELL_BACK;
        nr = cr - 5'd1; nc = cc - 5'd1;
      end
      DIR_UR: begin
        probe_ok = (cr != 5'd0) && (cc < grid_cols);
        pr = cr - 5'd1; pc = cc; want = CELL_FWD;
        nr = cr - 5'd1; nc = cc + 5'd1;
      end
      DIR_DL: begin
        probe_ok = (cr < grid_rows) && (cc != 5'd0);
        pr = cr; pc = cc - 5'd1; want = CELL_FWD;
        nr = cr + 5'd1; nc = cc - 5'd1;
      end
      default: begin
        probe_ok = (cr < grid_rows) && (cc < grid_cols);
        pr = cr; pc = cc; want = CELL_BACK;
        nr = cr + 5'd1; nc = cc + 5'd1;
      end
    endcase
  end

  logic [NW-1:0] nidx;
  assign nidx = NW'(nr * NCOLS + nc);
  assign cell_ra = CW'(pr * MAX_COLS + pc);
  assign vis_ra = nidx;
  assign q_ra = head[NW-1:0];

  logic acc;
  assign in_stall = (state != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign degree = res_degree;
  assign reachable = res_reach;
  assign bad_coordinate = res_bad;

  logic bad_wr, bad_deg, bad_path;
  assign bad_wr = (node_row >= grid_rows) || (node_col >= grid_cols);
  assign bad_deg = (node_row > grid_rows) || (node_col > grid_cols);
  assign bad_path = bad_deg || (target_row > grid_rows) || (target_col > grid_cols);

  always_comb begin
    cell_we = 1'b0;
    cell_wa = CW'(node_row * MAX_COLS + node_col);
    cell_wd = (cell_value == 2'd3) ? CELL_EMPTY : cell_value;
    vis_we = 1'b0;
    vis_wa = nidx;
    vis_wd = 1'b1;
    q_we = 1'b0;
    q_wa = tail[NW-1:0];
    q_wd = {nr, nc};
    unique case (state)
      S_CLR: begin
        cell_we = 1'b1;
        cell_wa = sweep[CW-1:0];
        cell_wd = CELL_EMPTY;
      end
      S_IDLE: cell_we = acc && (action == ACT_WRITE) && !bad_wr;
      S_VCLR: begin
        vis_we = 1'b1;
        vis_wa = sweep[NW-1:0];
        vis_wd = 1'b0;
      end
      S_START: begin
        vis_we = 1'b1;
        vis_wa = NW'(cr * NCOLS + cc);
        q_we = 1'b1;
        q_wa = '0;
        q_wd = {cr, cc};
      end
      S_VCHK: begin
        vis_we = (vis_q == 1'b0);
        q_we = (vis_q == 1'b0);
      end
      default: ;
    endcase
  end

  // The queue holds row and column side by side, so a dequeued node needs no index split.
  logic [4:0] q_row, q_col;
  always_comb begin
    q_row = queue_q[9:5];
    q_col = queue_q[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      grid_rows <= clamp(5'd16, MAXR);
      grid_cols <= clamp(5'd16, MAXC);
      sweep <= '0;
      head <= '0;
      tail <= '0;
      dir <= '0;
      deg_cnt <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ROWS[0:0]) grid_rows <= clamp(cfg_data, MAXR);
        else grid_cols <= clamp(cfg_data, MAXC);
      end
      unique case (state)
        S_CLR: begin
          if (sweep == QW'(CELLS - 1)) state <= S_IDLE;
          sweep <= (sweep == QW'(CELLS - 1)) ? '0 : sweep + QW'(1);
        end
        S_IDLE: if (acc) begin
          cr <= node_row; cc <= node_col; tr <= target_row; tc <= target_col;
          res_degree <= '0; res_reach <= 1'b0; res_bad <= 1'b0;
          dir <= '0; deg_cnt <= '0; sweep <= '0;
          case (action)
            ACT_WRITE: if (bad_wr) begin res_bad <= 1'b1; state <= S_OUT; end
            ACT_DEGREE: if (bad_deg) begin res_bad <= 1'b1; state <= S_OUT; end
                        else state <= S_DEG;
            ACT_PATH: if (bad_path) begin res_bad <= 1'b1; state <= S_OUT; end
                      else state <= S_VCLR;
            default: ;
          endcase
        end
        S_DEG: state <= S_DEGRD;
        S_DEGRD: begin
          if (probe_ok && cell_q == want) deg_cnt <= deg_cnt + 3'd1;
          dir <= dir + 2'd1;
          if (dir == 2'd3) begin
            res_degree <= deg_cnt + 3'((probe_ok && cell_q == want) ? 1 : 0);
            state <= S_OUT;
          end else state <= S_DEG;
        end
        S_VCLR: begin
          sweep <= sweep + QW'(1);
          if (sweep == QW'(NODES - 1)) state <= S_START;
        end
        S_START: begin
          head <= '0;
          tail <= QW'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (head == tail) state <= S_OUT;
          else state <= S_POPRD;
        end
        S_POPRD: begin
          cr <= q_row; cc <= q_col;
          head <= head + QW'(1);
          dir <= '0;
          if (q_row == tr && q_col == tc) begin
            res_reach <= 1'b1;
            state <= S_OUT;
          end else state <= S_NBR;
        end
        S_NBR: state <= S_NBRRD;
        S_NBRRD: begin
          if (probe_ok && cell_q == want) state <= S_VRD;
          else if (dir == 2'd3) state <= S_POP;
          else begin dir <= dir + 2'd1; state <= S_NBR; end
        end
        S_VRD: state <= S_VCHK;
        S_VCHK: begin
          if (vis_q == 1'b0) tail <= tail + QW'(1);
          if (dir == 2'd3) state <= S_POP;
          else begin dir <= dir + 2'd1; state <= S_NBR; end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
